/* hw/rtl/lts_pkg.sv */
// Shared types, widths and constants of the link timeout supervisor.
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

   // Channel addressing
   localparam int CHANNEL_W = 1;
   localparam int CHANNELS  = 2;
   localparam int SLOTS     = 2 ** CHANNEL_W;

   // Field widths
   localparam int TIME_W      = 32;
   localparam int BAD_W       = 4;
   localparam int CSR_INDEX_W = 2;

   // Stream payload widths, padded to whole bytes
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 48;

   // Bad-data counter limits
   localparam logic [BAD_W-1:0] BAD_DATA_LIMIT = 4'd10;
   localparam logic [BAD_W-1:0] BAD_MAX        = 4'd15;

   // Register values after reset
   localparam logic [TIME_W-1:0] ACTIVE_TIMEOUT_RST   = 32'd200;
   localparam logic [TIME_W-1:0] INACTIVE_TIMEOUT_RST = 32'd10000;
   localparam logic [TIME_W-1:0] BAD_WINDOW_RST       = 32'd50;
   localparam logic              CRITICAL_MODE_RST    = 1'b0;

   // Item opcodes
   localparam logic OP_CHECK   = 1'b0;
   localparam logic OP_CONNECT = 1'b1;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ACTIVE_TIMEOUT   = 2'd0,
      CSR_INACTIVE_TIMEOUT = 2'd1,
      CSR_BAD_WINDOW       = 2'd2,
      CSR_CRITICAL_MODE    = 2'd3
   } csr_index_type;

   // Result status codes
   typedef enum logic [2:0] {
      STATUS_IDLE      = 3'd0,
      STATUS_OK        = 3'd1,
      STATUS_LINK_LOST = 3'd2,
      STATUS_TIMEOUT   = 3'd3,
      STATUS_BAD_DATA  = 3'd4,
      STATUS_CONNECTED = 3'd5
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] active_timeout_ms;
      logic [TIME_W-1:0] inactive_timeout_ms;
      logic [TIME_W-1:0] bad_data_window_ms;
      logic              critical_mode;
   } cfg_type;

   typedef struct packed {
      logic              connected;
      logic              waiting;
      logic [TIME_W-1:0] last_msg_stamp;
      logic [TIME_W-1:0] last_bad_stamp;
      logic [BAD_W-1:0]  bad_counter;
   } chan_state_type;

   typedef struct packed {
      logic                 opcode;
      logic [CHANNEL_W-1:0] channel;
      logic [TIME_W-1:0]    now_ms;
      logic [TIME_W-1:0]    reported_msg_time;
      logic                 link_up;
      logic                 status_plugged;
      logic                 status_unplugged;
   } item_type;

   typedef struct packed {
      logic [CHANNEL_W-1:0] channel_out;
      status_type           status;
      logic                 late_flag;
      logic                 drop_link;
      logic [TIME_W-1:0]    lag_ms;
      logic [BAD_W-1:0]     bad_count;
      logic                 waiting_reconnect;
      logic                 connected_out;
   } result_type;

endpackage

`default_nettype wire

/* hw/rtl/link_timeout_supervisor.sv */
// Top level of the link timeout supervisor: stream ports, registers, channel state.
//
// Usage:
//   req channel carries one transaction per check or connect event. req_tuser
//   holds the opcode (0 check, 1 connect); req_tdata holds channel, now_ms,
//   reported_msg_time, link_up, status_plugged and status_unplugged.
//   rsp channel returns exactly one result per request, in order.
//   csr channel writes the timeout, window and critical-mode registers; it is
//   always ready and must only be used while no transaction is in flight.
// Path: an accepted request is registered in the input stage; its result is then
//   loaded into the result register, which drives rsp_tvalid and rsp_tdata.
// Throughput: one transaction per cycle while rsp_tready stays high; the channel
//   state read-modify-write completes in the single compute stage, so back-to-back
//   items on the same channel see each other's updates.
// Reset: synchronous, active high. Clears all channel state, empties both
//   stages and loads the register defaults (200, 10000, 50, critical off).
// Stall: while rsp_tready is low the result holds; one more request may be
//   taken into the input stage, after which req_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module link_timeout_supervisor (
   input  wire                               clock,
   input  wire                               reset,
   // request stream
   input  wire                               req_tvalid,
   output logic                              req_tready,
   // req_tdata: channel, now_ms[31:0], reported_msg_time[31:0], link_up,
   //            status_plugged, status_unplugged, 4 zero bits
   input  wire  [lts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   // req_tuser: opcode
   input  wire                               req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   // rsp_tdata: channel_out, status[2:0], late_flag, drop_link, lag_ms[31:0],
   //            bad_count[3:0], waiting_reconnect, connected_out, 4 zero bits
   output logic [lts_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   // register write port
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [lts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [lts_pkg::TIME_W-1:0]        csr_data
);
   import lts_pkg::*;

   cfg_type        cfg_ff;
   item_type       item_ff;
   item_type       item_in;
   logic           item_valid_ff;
   result_type     rsp_ff;
   logic           rsp_valid_ff;
   chan_state_type chan_ff [SLOTS];
   chan_state_type cur_state;
   chan_state_type nxt_state;
   result_type     step_res;
   logic           step_write;
   logic           advance;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_timeout_ms   <= ACTIVE_TIMEOUT_RST;
         cfg_ff.inactive_timeout_ms <= INACTIVE_TIMEOUT_RST;
         cfg_ff.bad_data_window_ms  <= BAD_WINDOW_RST;
         cfg_ff.critical_mode       <= CRITICAL_MODE_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_ACTIVE_TIMEOUT:   cfg_ff.active_timeout_ms   <= csr_data;
            CSR_INACTIVE_TIMEOUT: cfg_ff.inactive_timeout_ms <= csr_data;
            CSR_BAD_WINDOW:       cfg_ff.bad_data_window_ms  <= csr_data;
            CSR_CRITICAL_MODE:    cfg_ff.critical_mode       <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Unpack the request transaction
   assign item_in.opcode            = req_tuser;
   assign item_in.channel           = req_tdata[0];
   assign item_in.now_ms            = req_tdata[32:1];
   assign item_in.reported_msg_time = req_tdata[64:33];
   assign item_in.link_up           = req_tdata[65];
   assign item_in.status_plugged    = req_tdata[66];
   assign item_in.status_unplugged  = req_tdata[67];

   // Move the compute stage forward when the result slot is free
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= item_in;
      end
   end

   assign cur_state = chan_ff[item_ff.channel];

   lts_step u_step (
      .item     (item_ff),
      .cur      (cur_state),
      .cfg      (cfg_ff),
      .write_en (step_write),
      .nxt      (nxt_state),
      .res      (step_res)
   );

   // Commit channel state as the item leaves the compute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            chan_ff[i] <= '0;
         end
      end else if (item_valid_ff && advance && step_write) begin
         chan_ff[item_ff.channel] <= nxt_state;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item_valid_ff) begin
         rsp_ff <= step_res;
      end
   end

   // Pack the result with the first field in the lowest bits
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_ff.connected_out, rsp_ff.waiting_reconnect,
                        rsp_ff.bad_count, rsp_ff.lag_ms, rsp_ff.drop_link,
                        rsp_ff.late_flag, rsp_ff.status, rsp_ff.channel_out};

endmodule

`default_nettype wire

/* hw/rtl/lts_step.sv */
// Per-item decision logic: next channel state and result for one transaction.
`timescale 1ns / 1ps
`default_nettype none

module lts_step (
   input  wire  lts_pkg::item_type       item,
   input  wire  lts_pkg::chan_state_type cur,
   input  wire  lts_pkg::cfg_type        cfg,
   output logic                          write_en,
   output lts_pkg::chan_state_type       nxt,
   output lts_pkg::result_type           res
);
   import lts_pkg::*;

   logic              ch_ok;
   logic [TIME_W-1:0] stamp;
   logic [TIME_W-1:0] raw_lag;
   logic [TIME_W-1:0] lag;
   logic [TIME_W-1:0] bad_limit;
   logic [BAD_W-1:0]  bad_inc;

   assign ch_ok    = (int'(item.channel) < CHANNELS);
   assign write_en = ch_ok;

   // Take the reported time when newer, then measure lag against now
   assign stamp     = (item.reported_msg_time > cur.last_msg_stamp) ?
                      item.reported_msg_time : cur.last_msg_stamp;
   assign raw_lag   = item.now_ms - stamp;
   // A waiting channel restamps to now, so its lag is zero
   assign lag       = (!cur.waiting && (item.now_ms > stamp)) ? raw_lag : '0;
   assign bad_limit = cur.last_bad_stamp + cfg.bad_data_window_ms;
   assign bad_inc   = (cur.bad_counter == BAD_MAX) ? BAD_MAX :
                      cur.bad_counter + {{(BAD_W-1){1'b0}}, 1'b1};

   always_comb begin
      nxt            = cur;
      res            = '0;
      res.status     = STATUS_IDLE;
      res.channel_out = item.channel;

      if (item.opcode == OP_CONNECT) begin
         nxt.connected      = 1'b1;
         nxt.last_msg_stamp = item.now_ms;
         res.status         = STATUS_CONNECTED;
      end else if (cur.connected) begin
         if (!item.link_up) begin
            // Link lost: keep stamps and count, wait for reconnect
            nxt.waiting   = 1'b1;
            nxt.connected = 1'b0;
            res.status    = STATUS_LINK_LOST;
         end else begin
            nxt.last_msg_stamp = cur.waiting ? item.now_ms : stamp;
            if (cur.waiting && (raw_lag < cfg.active_timeout_ms)) begin
               nxt.waiting = 1'b0;
            end
            res.lag_ms    = lag;
            res.late_flag = cfg.critical_mode && (lag > cfg.active_timeout_ms);

            if (lag > cfg.inactive_timeout_ms) begin
               // Inactive timeout: clear the channel and drop the link
               nxt           = '0;
               nxt.waiting   = 1'b1;
               res.status    = STATUS_TIMEOUT;
               res.drop_link = 1'b1;
            end else if (!item.status_plugged && !item.status_unplugged) begin
               // Bad data: count at most once per window
               if (item.now_ms > bad_limit) begin
                  nxt.bad_counter    = bad_inc;
                  nxt.last_bad_stamp = item.now_ms;
               end
               if (nxt.bad_counter > BAD_DATA_LIMIT) begin
                  nxt           = '0;
                  nxt.waiting   = 1'b1;
                  res.status    = STATUS_BAD_DATA;
                  res.drop_link = 1'b1;
               end else begin
                  res.status = STATUS_OK;
               end
            end else begin
               nxt.bad_counter = '0;
               res.status      = STATUS_OK;
            end
         end
      end

      res.bad_count         = nxt.bad_counter;
      res.waiting_reconnect = nxt.waiting;
      res.connected_out     = nxt.connected;

      // Channel outside the supervised range: report as idle and empty
      if (!ch_ok) begin
         nxt                   = cur;
         res.status            = STATUS_IDLE;
         res.late_flag         = 1'b0;
         res.drop_link         = 1'b0;
         res.lag_ms            = '0;
         res.bad_count         = '0;
         res.waiting_reconnect = 1'b0;
         res.connected_out     = 1'b0;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/lts_checker.sv */
// Port-level checks of the link timeout supervisor and their bind.
`timescale 1ns / 1ps
`default_nettype none

module lts_port_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [lts_pkg::RSP_TDATA_W-1:0]  rsp_tdata
);
   import lts_pkg::*;

   logic [2:0] status;
   logic       late;
   logic       drop;
   logic       waiting;
   logic       conn;
   logic [BAD_W-1:0]  bad;
   logic [TIME_W-1:0] lag;

   assign status  = rsp_tdata[3:1];
   assign late    = rsp_tdata[4];
   assign drop    = rsp_tdata[5];
   assign lag     = rsp_tdata[37:6];
   assign bad     = rsp_tdata[41:38];
   assign waiting = rsp_tdata[42];
   assign conn    = rsp_tdata[43];

   // Stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Drop requests come only with a timeout or bad-data status
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && drop |-> status == STATUS_TIMEOUT || status == STATUS_BAD_DATA)
      else $error("drop without drop status");

   // A dropped channel is cleared and waits for reconnect
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (status == STATUS_TIMEOUT || status == STATUS_BAD_DATA) |->
         drop && waiting && !conn && bad == '0)
      else $error("dropped channel not cleared");

   // A connect result reports a connected channel with no lag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status == STATUS_CONNECTED |-> conn && !late && !drop && lag == '0)
      else $error("connect result inconsistent");

endmodule

bind link_timeout_supervisor lts_port_checker u_lts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* dv/lts_checker.sv */
// Checker for the link timeout supervisor: mirrors the channel state, predicts and compares results.
`timescale 1ns / 1ps

module lts_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   input  wire                               req_tready,
   input  wire  [lts_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  wire                               req_tuser,
   input  wire                               rsp_tvalid,
   input  wire                               rsp_tready,
   input  wire  [lts_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input  wire                               csr_valid,
   input  wire                               csr_ready,
   input  wire  [lts_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire  [lts_pkg::TIME_W-1:0]        csr_data,
   output int                                error_count,
   output int                                pending_count
);
   import lts_pkg::*;

   cfg_type        regs;
   chan_state_type link_state [CHANNELS];
   result_type     verdict_q [$];
   int             mismatches;

   initial begin
      error_count   = 0;
      pending_count = 0;
      mismatches    = 0;
   end

   // Apply one transaction to the mirrored channel state and return its result
   function automatic result_type supervise(input item_type it);
      result_type     r;
      chan_state_type s;
      logic [TIME_W-1:0] lag;
      logic [TIME_W-1:0] bad_limit;
      int             ch;
      begin
         r             = '0;
         r.status      = STATUS_IDLE;
         ch            = int'(it.channel);
         r.channel_out = it.channel;
         s             = link_state[ch];
         if (it.opcode == OP_CONNECT) begin
            s.connected      = 1'b1;
            s.last_msg_stamp = it.now_ms;
            r.status         = STATUS_CONNECTED;
         end else if (s.connected) begin
            if (!it.link_up) begin
               s.waiting   = 1'b1;
               s.connected = 1'b0;
               r.status    = STATUS_LINK_LOST;
            end else begin
               // take a newer report, then settle a pending reconnect
               if (it.reported_msg_time > s.last_msg_stamp)
                  s.last_msg_stamp = it.reported_msg_time;
               lag = it.now_ms - s.last_msg_stamp;
               if (s.waiting) begin
                  if (lag < regs.active_timeout_ms)
                     s.waiting = 1'b0;
                  s.last_msg_stamp = it.now_ms;
               end
               lag = (it.now_ms > s.last_msg_stamp) ? it.now_ms - s.last_msg_stamp : '0;
               r.late_flag = regs.critical_mode && (lag > regs.active_timeout_ms);
               r.lag_ms    = lag;
               if (lag > regs.inactive_timeout_ms) begin
                  s           = '0;
                  s.waiting   = 1'b1;
                  r.status    = STATUS_TIMEOUT;
                  r.drop_link = 1'b1;
               end else if (!it.status_plugged && !it.status_unplugged) begin
                  // count bad data at most once per window
                  bad_limit = s.last_bad_stamp + regs.bad_data_window_ms;
                  if (it.now_ms > bad_limit) begin
                     if (s.bad_counter < BAD_MAX)
                        s.bad_counter = s.bad_counter + 1'b1;
                     s.last_bad_stamp = it.now_ms;
                  end
                  if (s.bad_counter > BAD_DATA_LIMIT) begin
                     s           = '0;
                     s.waiting   = 1'b1;
                     r.status    = STATUS_BAD_DATA;
                     r.drop_link = 1'b1;
                  end else begin
                     r.status = STATUS_OK;
                  end
               end else begin
                  s.bad_counter = '0;
                  r.status      = STATUS_OK;
               end
            end
         end
         link_state[ch]      = s;
         r.bad_count         = s.bad_counter;
         r.waiting_reconnect = s.waiting;
         r.connected_out     = s.connected;
         return r;
      end
   endfunction

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", field, want, seen);
         mismatches++;
      end
   endtask

   // Track register writes, predict on each request, compare on each response
   always @(posedge clock) begin : watch
      item_type   it;
      result_type want;
      if (reset) begin
         regs.active_timeout_ms   = ACTIVE_TIMEOUT_RST;
         regs.inactive_timeout_ms = INACTIVE_TIMEOUT_RST;
         regs.bad_data_window_ms  = BAD_WINDOW_RST;
         regs.critical_mode       = CRITICAL_MODE_RST;
         for (int c = 0; c < CHANNELS; c++)
            link_state[c] = '0;
         verdict_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ACTIVE_TIMEOUT:   regs.active_timeout_ms   = csr_data;
               CSR_INACTIVE_TIMEOUT: regs.inactive_timeout_ms = csr_data;
               CSR_BAD_WINDOW:       regs.bad_data_window_ms  = csr_data;
               CSR_CRITICAL_MODE:    regs.critical_mode       = csr_data[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            it.opcode            = req_tuser;
            it.channel           = req_tdata[0];
            it.now_ms            = req_tdata[32:1];
            it.reported_msg_time = req_tdata[64:33];
            it.link_up           = req_tdata[65];
            it.status_plugged    = req_tdata[66];
            it.status_unplugged  = req_tdata[67];
            verdict_q.push_back(supervise(it));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (verdict_q.size() == 0) begin
               $error("response transaction with no request outstanding: %0h", rsp_tdata);
               mismatches++;
            end else begin
               want = verdict_q.pop_front();
               compare_field("channel_out", want.channel_out, rsp_tdata[0]);
               compare_field("status", want.status, rsp_tdata[3:1]);
               compare_field("late_flag", want.late_flag, rsp_tdata[4]);
               compare_field("drop_link", want.drop_link, rsp_tdata[5]);
               compare_field("lag_ms", want.lag_ms, rsp_tdata[37:6]);
               compare_field("bad_count", want.bad_count, rsp_tdata[41:38]);
               compare_field("waiting_reconnect", want.waiting_reconnect, rsp_tdata[42]);
               compare_field("connected_out", want.connected_out, rsp_tdata[43]);
            end
         end
      end
      pending_count <= verdict_q.size();
      error_count   <= mismatches;
   end

endmodule

/* dv/tb_top.sv */
// Testbench top for the link timeout supervisor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import lts_pkg::*;

   localparam int PHASES       = 5;
   localparam int PHASE_ITEMS  = 170;
   localparam int HOLD_CYCLES  = 300;
   localparam int CYCLE_LIMIT  = 200000;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_W-1:0]     req_tdata  = '0;
   logic                       req_tuser  = 1'b0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0]     rsp_tdata;
   logic                       csr_valid  = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index  = '0;
   logic [TIME_W-1:0]          csr_data   = '0;

   int                         error_count;
   int                         pending_count;
   int unsigned                cycle_count = 0;

   // Stimulus shaping; steady and hold_request are shared with the receiver
   bit                         steady       = 1'b0;
   bit                         hold_request = 1'b0;
   logic [TIME_W-1:0]          clock_ms [CHANNELS];
   int unsigned                bad_run  [CHANNELS];
   int unsigned                step_hi;
   logic [TIME_W-1:0]          window_ms;

   link_timeout_supervisor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   lts_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // Response side: random back-pressure, one long hold-off on request
   initial begin : receiver
      bit hold_served;
      hold_served = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (hold_request && !hold_served) begin
            hold_served = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= steady || ($urandom_range(0, 99) >= 27);
         end
      end
   end

   // Offer one transaction, idling first at random, and hold until accepted
   task automatic offer(input item_type it);
      while (!steady && $urandom_range(0, 99) < 27) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.opcode;
      req_tdata  <= {4'b0, it.status_unplugged, it.status_plugged, it.link_up,
                     it.reported_msg_time, it.now_ms, it.channel};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic offer_fields(input logic op, input logic ch, input logic [31:0] now,
                               input logic [31:0] rep, input logic up,
                               input logic plugged, input logic unplugged);
      item_type it;
      it.opcode            = op;
      it.channel           = ch;
      it.now_ms            = now;
      it.reported_msg_time = rep;
      it.link_up           = up;
      it.status_plugged    = plugged;
      it.status_unplugged  = unplugged;
      offer(it);
   endtask

   // Hold valid across back-to-back writes; the caller lowers it
   task automatic write_reg(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // Mostly plausible link traffic per channel, with bad-data bursts and some noise
   function automatic item_type make_item();
      item_type    it;
      int unsigned ch;
      int unsigned roll;
      it = '0;
      if ($urandom_range(0, 99) < 8) begin
         it.opcode            = 1'($urandom_range(0, 1));
         it.channel           = CHANNEL_W'($urandom_range(0, 1));
         it.now_ms            = $urandom;
         it.reported_msg_time = $urandom;
         it.link_up           = 1'($urandom_range(0, 1));
         it.status_plugged    = 1'($urandom_range(0, 1));
         it.status_unplugged  = 1'($urandom_range(0, 1));
         return it;
      end
      ch         = $urandom_range(0, CHANNELS - 1);
      it.channel = CHANNEL_W'(ch);
      it.opcode  = OP_CHECK;
      it.link_up = 1'b1;
      // a burst spaces bad reports just past the window so each one counts
      if (bad_run[ch] != 0) begin
         bad_run[ch]--;
         clock_ms[ch]         = clock_ms[ch] + window_ms + 1 + $urandom_range(0, 9);
         it.now_ms            = clock_ms[ch];
         it.reported_msg_time = clock_ms[ch];
         return it;
      end
      roll = $urandom_range(0, 99);
      if (roll < 85)
         clock_ms[ch] = clock_ms[ch] + $urandom_range(0, step_hi);
      else if (roll < 96)
         clock_ms[ch] = clock_ms[ch] + $urandom_range(step_hi, 20 * step_hi + 20000);
      else
         clock_ms[ch] = clock_ms[ch] + $urandom;
      it.now_ms = clock_ms[ch];
      if ($urandom_range(0, 99) < 12)
         it.opcode = OP_CONNECT;
      case ($urandom_range(0, 4))
         0: it.reported_msg_time = it.now_ms;
         1: it.reported_msg_time = it.now_ms - $urandom_range(0, step_hi);
         2: it.reported_msg_time = it.now_ms + $urandom_range(0, step_hi);
         3: it.reported_msg_time = '0;
         default: it.reported_msg_time = $urandom;
      endcase
      it.link_up = $urandom_range(0, 99) >= 6;
      roll = $urandom_range(0, 9);
      it.status_plugged   = (roll <= 5) || (roll == 7);
      it.status_unplugged = (roll == 6) || (roll == 7);
      if ($urandom_range(0, 99) < 4)
         bad_run[ch] = $urandom_range(11, 14);
      return it;
   endfunction

   task automatic run_phase(input int phase);
      if (phase == 0) begin
         step_hi   = 120;
         window_ms = BAD_WINDOW_RST;
         // directed: reset settings, both channels
         offer_fields(OP_CHECK,   1'b0, 32'd100,  32'd0,    1'b1, 1'b1, 1'b0);
         offer_fields(OP_CONNECT, 1'b0, 32'd1000, 32'd0,    1'b1, 1'b1, 1'b0);
         offer_fields(OP_CHECK,   1'b0, 32'd1100, 32'd1050, 1'b1, 1'b1, 1'b0);
         // report newer than now leaves no lag
         offer_fields(OP_CHECK,   1'b0, 32'd1200, 32'd2000, 1'b1, 1'b0, 1'b1);
         // bad data counted, then ignored inside the window, then cleared
         offer_fields(OP_CHECK,   1'b0, 32'd2100, 32'd0,    1'b1, 1'b0, 1'b0);
         offer_fields(OP_CHECK,   1'b0, 32'd2120, 32'd0,    1'b1, 1'b0, 1'b0);
         offer_fields(OP_CHECK,   1'b0, 32'd2130, 32'd0,    1'b1, 1'b1, 1'b1);
         // link down, then a check on the dropped channel
         offer_fields(OP_CHECK,   1'b0, 32'd2140, 32'd0,    1'b0, 1'b1, 1'b0);
         offer_fields(OP_CHECK,   1'b0, 32'd2150, 32'd0,    1'b1, 1'b1, 1'b0);
         // reconnect: first lag too long to clear waiting, second short enough
         offer_fields(OP_CONNECT, 1'b0, 32'd5000, 32'd0,    1'b1, 1'b1, 1'b0);
         offer_fields(OP_CHECK,   1'b0, 32'd5300, 32'd0,    1'b1, 1'b1, 1'b0);
         offer_fields(OP_CHECK,   1'b0, 32'd5400, 32'd5390, 1'b1, 1'b1, 1'b0);
         // stamp ahead of a wrapped clock
         offer_fields(OP_CONNECT, 1'b1, 32'hFFFF_FFF0, 32'd0, 1'b1, 1'b1, 1'b0);
         offer_fields(OP_CHECK,   1'b1, 32'd10,   32'd0,    1'b1, 1'b1, 1'b0);
         // inactive timeout just past the limit
         offer_fields(OP_CHECK,   1'b0, 32'd15401, 32'd0,   1'b1, 1'b1, 1'b0);
         offer_fields(OP_CHECK,   1'b0, 32'd15402, 32'd0,   1'b1, 1'b1, 1'b0);
         // all-ones and all-zeros fields
         offer_fields(OP_CONNECT, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
         offer_fields(OP_CHECK,   1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1);
         offer_fields(OP_CHECK,   1'b1, 32'd0,    32'd0,    1'b0, 1'b0, 1'b0);
         for (int c = 0; c < CHANNELS; c++)
            clock_ms[c] = 32'd20000;
      end else begin
         // drain before touching the registers
         req_tvalid <= 1'b0;
         @(posedge clock);
         while (pending_count != 0) @(posedge clock);
         repeat (4) @(posedge clock);
         case (phase)
            1: begin
               write_reg(CSR_ACTIVE_TIMEOUT, 32'd100);
               write_reg(CSR_INACTIVE_TIMEOUT, 32'd1000);
               write_reg(CSR_BAD_WINDOW, 32'd20);
               write_reg(CSR_CRITICAL_MODE, 32'd1);
               step_hi = 60;
            end
            2: begin
               write_reg(CSR_ACTIVE_TIMEOUT, 32'd0);
               write_reg(CSR_INACTIVE_TIMEOUT, 32'd0);
               write_reg(CSR_BAD_WINDOW, 32'd0);
               step_hi = 4;
            end
            3: begin
               write_reg(CSR_ACTIVE_TIMEOUT, 32'hFFFF_FFFF);
               write_reg(CSR_INACTIVE_TIMEOUT, 32'hFFFF_FFFF);
               write_reg(CSR_BAD_WINDOW, 32'hFFFF_FFFF);
               write_reg(CSR_CRITICAL_MODE, 32'd0);
               step_hi = 3000;
               // run the clocks across the 32-bit wrap
               for (int c = 0; c < CHANNELS; c++)
                  clock_ms[c] = 32'hFFFF_F000;
            end
            default: begin
               write_reg(CSR_ACTIVE_TIMEOUT, $urandom_range(1, 500));
               write_reg(CSR_INACTIVE_TIMEOUT, $urandom_range(500, 20000));
               window_ms = $urandom_range(0, 200);
               write_reg(CSR_BAD_WINDOW, window_ms);
               write_reg(CSR_CRITICAL_MODE, $urandom_range(0, 1));
               step_hi = 400;
            end
         endcase
         csr_valid <= 1'b0;
         case (phase)
            1: window_ms = 32'd20;
            2: window_ms = 32'd0;
            3: window_ms = 32'hFFFF_FFFF;
            default: ;
         endcase
         for (int c = 0; c < CHANNELS; c++)
            bad_run[c] = 0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         // one steady stretch on both sides, with the long hold-off inside it
         steady = (phase == 1) && (n >= 40) && (n < 140);
         if (phase == 1 && n == 60)
            hold_request <= 1'b1;
         offer(make_item());
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int c = 0; c < CHANNELS; c++) begin
         clock_ms[c] = '0;
         bad_run[c]  = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int p = 0; p < PHASES; p++)
         run_phase(p);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/lts_pkg.sv
hw/rtl/lts_step.sv
hw/rtl/link_timeout_supervisor.sv
hw/rtl/lts_checker.sv
dv/lts_checker.sv
dv/tb_top.sv
